FILE: design/ptfa_pkg.sv
// Shared types, constants and codes for the page table frame allocator.
package ptfa_pkg;

  localparam int FRAMES_DEFAULT   = 64;
  localparam int MEM_LOG2_DEFAULT = 26;

  localparam int PID_W   = 32;
  localparam int PAGE_W  = 31;
  localparam int VA_W    = 31;
  localparam int SHIFT_W = 5;
  localparam int FRAME_W = 16;
  localparam int PA_W    = 26;
  localparam int STAT_W  = 2;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

  localparam logic ACT_ADD       = 1'b0;
  localparam logic ACT_TRANSLATE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ALREADY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNMAPPED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } ptfa_state_t;

  typedef struct packed {
    logic              action;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] map_page;
    logic [VA_W-1:0]   xlate_addr;
  } ptfa_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame_index;
    logic [PA_W-1:0]    physical_address;
  } ptfa_rsp_t;

  // Lookup key broadcast to every cell.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
  } ptfa_key_t;

  // Claim of one frame by an add request.
  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] idx;
  } ptfa_wr_t;

  // Search token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic               active;
    logic               hit;
    logic [FRAME_W-1:0] hit_idx;
    logic               free_found;
    logic [FRAME_W-1:0] free_idx;
  } ptfa_tok_t;

endpackage

FILE: design/ptfa_cell.sv
// One frame entry of the allocator chain: used bit, owner key and a token stage.
module ptfa_cell #(
  parameter int IDX   = 0,
  parameter int LIM_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  ptfa_pkg::ptfa_key_t key,
  input  logic [LIM_W-1:0]    lim,
  input  ptfa_pkg::ptfa_wr_t  wr,
  input  ptfa_pkg::ptfa_tok_t tok_in,
  output ptfa_pkg::ptfa_tok_t tok_out
);
  import ptfa_pkg::*;

  localparam logic [FRAME_W-1:0] MY_IDX = FRAME_W'(IDX);
  localparam logic [LIM_W-1:0]   MY_POS = LIM_W'(IDX);

  logic      used;
  ptfa_key_t owner;
  ptfa_tok_t tok_next;
  logic      match;
  logic      eligible;

  always_comb begin
    match    = used && (owner == key);
    eligible = !used && (MY_POS < lim);
    tok_next = tok_in;
    if (match && !tok_in.hit) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = MY_IDX;
    end
    // The first free usable frame seen along the chain is the lowest one.
    if (eligible && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && (wr.idx == MY_IDX)) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == MY_IDX)) begin
      owner <= key;
    end
  end

endmodule

FILE: design/page_table_frame_allocator.sv
// Top level of the page table frame allocator: request control and the chain of frame cells.
// Requests are served one at a time: req_stall is high outside ST_IDLE, so a new request word
// is taken only after the last response word is loaded. The search token visits one
// frame cell per cycle, so the length of the cell chain sets how long a search runs.
// Reset (rst, synchronous, active high) clears every used bit, the search token,
// the response valid and the controller state, and sets page_shift to 12.
module page_table_frame_allocator #(
  parameter int FRAMES            = ptfa_pkg::FRAMES_DEFAULT,
  parameter int MEMORY_BYTES_LOG2 = ptfa_pkg::MEM_LOG2_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ptfa_pkg::ptfa_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ptfa_pkg::ptfa_rsp_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  import ptfa_pkg::*;

  // The usable frame count lies in 0..FRAMES, so it needs $clog2(FRAMES + 1) bits.
  localparam int LIM_W = $clog2(FRAMES + 1);
  localparam logic [32:0] MEM_SIZE = 33'(1) << MEMORY_BYTES_LOG2;

  // Configuration. The user must write only while the block is idle; the block
  // itself does not enforce this. The port is always ready.
  logic [SHIFT_W-1:0] page_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= PAGE_SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      page_shift <= cfg_data;
    end
  end

  // Controller state and the request that is being served.
  ptfa_state_t       state, state_next;
  logic              start;
  logic              action;
  ptfa_key_t         key;
  logic [VA_W-1:0]   offset;
  logic [LIM_W-1:0]  lim;
  ptfa_tok_t         res_tok;

  logic              accept;
  logic              load;
  ptfa_wr_t          wr;
  ptfa_rsp_t         rsp_next;
  logic [32:0]       mem_frames;
  logic [LIM_W-1:0]  lim_next;
  logic [VA_W-1:0]   offset_mask;
  logic [PA_W-1:0]   frame_base;

  // tok[0] enters the first cell; tok[i + 1] leaves cell i.
  ptfa_tok_t         tok [FRAMES+1];

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // Usable frames: the smaller of FRAMES and the memory size in pages.
  always_comb begin
    mem_frames  = MEM_SIZE >> page_shift;
    lim_next    = (mem_frames > 33'(FRAMES)) ? LIM_W'(FRAMES) : LIM_W'(mem_frames);
    offset_mask = ~({VA_W{1'b1}} << page_shift);
  end

  // Next state, the frame claim and the response word.
  always_comb begin
    state_next = state;
    load       = 1'b0;
    wr         = '0;
    frame_base = PA_W'(res_tok.hit_idx) << page_shift;
    rsp_next   = '0;

    if (action == ACT_ADD) begin
      if (res_tok.hit) begin
        rsp_next.status = STAT_ALREADY;
      end else if (res_tok.free_found) begin
        rsp_next.status      = STAT_OK;
        rsp_next.frame_index = res_tok.free_idx;
      end else begin
        rsp_next.status = STAT_FULL;
      end
    end else begin
      if (res_tok.hit) begin
        rsp_next.status           = STAT_OK;
        rsp_next.frame_index      = res_tok.hit_idx;
        rsp_next.physical_address = frame_base + offset[PA_W-1:0];
      end else begin
        rsp_next.status = STAT_UNMAPPED;
      end
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // The token has passed the last cell once it shows up at the chain end.
        if (tok[FRAMES].active) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the finished result until the response register is free.
        if (!rsp_valid || !rsp_stall) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          wr.en      = (action == ACT_ADD) && !res_tok.hit && res_tok.free_found;
          wr.idx     = res_tok.free_idx;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request payload, search result and response word.
  always_ff @(posedge clk) begin
    if (accept) begin
      action  <= req.action;
      key.pid <= req.pid;
      lim     <= lim_next;
      if (req.action == ACT_ADD) begin
        key.page <= req.map_page;
        offset   <= '0;
      end else begin
        key.page <= PAGE_W'(req.xlate_addr >> page_shift);
        offset   <= req.xlate_addr & offset_mask;
      end
    end
    if ((state == ST_SEARCH) && tok[FRAMES].active) begin
      res_tok <= tok[FRAMES];
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

  // A fresh token enters the chain in the cycle after a request is accepted.
  assign tok[0] = '{active: start, default: '0};

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    ptfa_cell #(
      .IDX   (i),
      .LIM_W (LIM_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .lim     (lim),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

`ifndef SYNTHESIS
  a_token_only_in_search: assert property (@(posedge clk) disable iff (rst)
    tok[FRAMES].active |-> (state == ST_SEARCH))
    else $error("search token left the chain outside of a search");

  a_claim_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> ((state == ST_FINISH) && (action == ACT_ADD) && load))
    else $error("frame claimed outside of a finishing add");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == ST_SEARCH) && start))
    else $error("accepted request did not start a search");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_FINISH))
    else $error("response word raised without a finished search");
`endif

endmodule
